>>> rtl/core/aescf_pkg.sv
// Shared types, tables and byte-level functions for the custom-field cipher core.
// Used by the stage modules and the top level; depends on nothing.
package aescf_pkg;

   localparam int NumRounds = 10;

   typedef logic [7:0]   byte_type;
   typedef logic [127:0] block_type;
   typedef byte_type     tab_type [256];
   typedef byte_type     rcon_arr_type [NumRounds];

   // Payload carried from stage to stage
   typedef struct packed {
      logic      cmd;
      block_type state;
      block_type key;
   } stage_type;

   localparam logic CmdEncrypt = 1'b0;
   localparam logic CmdDecrypt = 1'b1;

   localparam logic CsrKeyUpper = 1'b0;
   localparam logic CsrKeyLower = 1'b1;

   localparam tab_type SBOX = '{
      8'd21,8'd10,8'd59,8'd33,8'd2,8'd199,8'd15,8'd188,
      8'd63,8'd114,8'd221,8'd138,8'd24,8'd153,8'd193,8'd91,
      8'd161,8'd47,8'd166,8'd79,8'd208,8'd1,8'd218,8'd80,
      8'd50,8'd38,8'd83,8'd9,8'd127,8'd96,8'd147,8'd58,
      8'd238,8'd206,8'd169,8'd187,8'd204,8'd194,8'd56,8'd248,
      8'd247,8'd205,8'd190,8'd251,8'd242,8'd32,8'd22,8'd34,
      8'd134,8'd145,8'd45,8'd3,8'd151,8'd35,8'd186,8'd117,
      8'd129,8'd23,8'd175,8'd68,8'd86,8'd4,8'd130,8'd25,
      8'd232,8'd17,8'd89,8'd5,8'd234,8'd214,8'd227,8'd229,
      8'd88,8'd196,8'd254,8'd213,8'd131,8'd27,8'd66,8'd159,
      8'd100,8'd136,8'd216,8'd105,8'd192,8'd217,8'd195,8'd253,
      8'd71,8'd53,8'd143,8'd252,8'd148,8'd155,8'd142,8'd7,
      8'd125,8'd84,8'd87,8'd163,8'd168,8'd78,8'd191,8'd113,
      8'd245,8'd177,8'd14,8'd210,8'd99,8'd55,8'd132,8'd167,
      8'd95,8'd198,8'd20,8'd202,8'd72,8'd16,8'd189,8'd6,
      8'd180,8'd231,8'd157,8'd162,8'd222,8'd176,8'd178,8'd172,
      8'd74,8'd67,8'd182,8'd215,8'd146,8'd244,8'd29,8'd118,
      8'd75,8'd49,8'd85,8'd133,8'd207,8'd135,8'd109,8'd237,
      8'd18,8'd112,8'd92,8'd154,8'd224,8'd158,8'd212,8'd120,
      8'd94,8'd37,8'd179,8'd122,8'd31,8'd51,8'd241,8'd233,
      8'd12,8'd137,8'd219,8'd42,8'd243,8'd70,8'd43,8'd62,
      8'd255,8'd8,8'd115,8'd110,8'd126,8'd220,8'd97,8'd226,
      8'd60,8'd123,8'd164,8'd200,8'd249,8'd141,8'd225,8'd11,
      8'd116,8'd13,8'd82,8'd183,8'd121,8'd150,8'd28,8'd57,
      8'd128,8'd104,8'd181,8'd40,8'd52,8'd36,8'd239,8'd44,
      8'd106,8'd69,8'd184,8'd139,8'd64,8'd223,8'd39,8'd171,
      8'd101,8'd173,8'd230,8'd235,8'd152,8'd30,8'd246,8'd209,
      8'd46,8'd98,8'd165,8'd90,8'd124,8'd170,8'd76,8'd61,
      8'd48,8'd228,8'd93,8'd119,8'd149,8'd211,8'd250,8'd144,
      8'd26,8'd236,8'd54,8'd203,8'd65,8'd140,8'd156,8'd73,
      8'd197,8'd185,8'd108,8'd160,8'd240,8'd0,8'd111,8'd107,
      8'd81,8'd77,8'd102,8'd19,8'd103,8'd41,8'd201,8'd174
   };

   localparam rcon_arr_type RCON = '{
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h4d, 8'h9a
   };

   // Inverse table: lowest preimage wins, bytes never produced map to themselves
   function automatic tab_type build_inv();
      tab_type    inv;
      logic [255:0] seen;
      seen = '0;
      for (int v = 0; v < 256; v++) begin
         inv[v] = byte_type'(v);
      end
      for (int v = 0; v < 256; v++) begin
         if (!seen[SBOX[v]]) begin
            seen[SBOX[v]] = 1'b1;
            inv[SBOX[v]]  = byte_type'(v);
         end
      end
      return inv;
   endfunction

   localparam tab_type INV_SBOX = build_inv();

   function automatic byte_type get_byte(block_type b, int i);
      return b[127 - 8*i -: 8];
   endfunction

   function automatic byte_type gf_dbl(byte_type x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h4d : 8'h00);
   endfunction

   function automatic block_type sub_fwd(block_type b);
      block_type r;
      for (int i = 0; i < 16; i++) begin
         r[127 - 8*i -: 8] = SBOX[get_byte(b, i)];
      end
      return r;
   endfunction

   function automatic block_type sub_inv(block_type b);
      block_type r;
      for (int i = 0; i < 16; i++) begin
         r[127 - 8*i -: 8] = INV_SBOX[get_byte(b, i)];
      end
      return r;
   endfunction

   function automatic block_type shift_fwd(block_type b);
      block_type r;
      for (int c = 0; c < 4; c++) begin
         for (int w = 0; w < 4; w++) begin
            r[127 - 8*(4*c + w) -: 8] = get_byte(b, 4*((c + w) % 4) + w);
         end
      end
      return r;
   endfunction

   function automatic block_type shift_inv(block_type b);
      block_type r;
      for (int c = 0; c < 4; c++) begin
         for (int w = 0; w < 4; w++) begin
            r[127 - 8*(4*c + w) -: 8] = get_byte(b, 4*((c - w + 4) % 4) + w);
         end
      end
      return r;
   endfunction

   function automatic block_type mix_fwd(block_type b);
      block_type r;
      byte_type  a0, a1, a2, a3, al;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(b, 4*c);
         a1 = get_byte(b, 4*c + 1);
         a2 = get_byte(b, 4*c + 2);
         a3 = get_byte(b, 4*c + 3);
         al = a0 ^ a1 ^ a2 ^ a3;
         r[127 - 32*c -: 8]  = a0 ^ al ^ gf_dbl(a0 ^ a1);
         r[119 - 32*c -: 8]  = a1 ^ al ^ gf_dbl(a1 ^ a2);
         r[111 - 32*c -: 8]  = a2 ^ al ^ gf_dbl(a2 ^ a3);
         r[103 - 32*c -: 8]  = a3 ^ al ^ gf_dbl(a3 ^ a0);
      end
      return r;
   endfunction

   // Multiply by 9, 11, 13, 14 through truncated doublings
   function automatic byte_type mul_n(byte_type x, byte_type n);
      byte_type x2, x4, x8, acc;
      x2  = gf_dbl(x);
      x4  = gf_dbl(x2);
      x8  = gf_dbl(x4);
      acc = x8;
      if (n[0]) acc = acc ^ x;
      if (n[1]) acc = acc ^ x2;
      if (n[2]) acc = acc ^ x4;
      return acc;
   endfunction

   function automatic block_type mix_inv(block_type b);
      block_type r;
      byte_type  a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(b, 4*c);
         a1 = get_byte(b, 4*c + 1);
         a2 = get_byte(b, 4*c + 2);
         a3 = get_byte(b, 4*c + 3);
         r[127 - 32*c -: 8] = mul_n(a0, 8'h0e) ^ mul_n(a1, 8'h0b)
                              ^ mul_n(a2, 8'h0d) ^ mul_n(a3, 8'h09);
         r[119 - 32*c -: 8] = mul_n(a0, 8'h09) ^ mul_n(a1, 8'h0e)
                              ^ mul_n(a2, 8'h0b) ^ mul_n(a3, 8'h0d);
         r[111 - 32*c -: 8] = mul_n(a0, 8'h0d) ^ mul_n(a1, 8'h09)
                              ^ mul_n(a2, 8'h0e) ^ mul_n(a3, 8'h0b);
         r[103 - 32*c -: 8] = mul_n(a0, 8'h0b) ^ mul_n(a1, 8'h0d)
                              ^ mul_n(a2, 8'h09) ^ mul_n(a3, 8'h0e);
      end
      return r;
   endfunction

   // Rotated, substituted last word with round constant
   function automatic logic [31:0] key_core(block_type p, byte_type rc);
      return {SBOX[get_byte(p, 13)] ^ rc, SBOX[get_byte(p, 14)],
              SBOX[get_byte(p, 15)], SBOX[get_byte(p, 12)]};
   endfunction

   function automatic block_type key_fwd(block_type p, byte_type rc);
      block_type q;
      q[127:96] = p[127:96] ^ key_core(p, rc);
      q[95:64]  = p[95:64] ^ q[127:96];
      q[63:32]  = p[63:32] ^ q[95:64];
      q[31:0]   = p[31:0]  ^ q[63:32];
      return q;
   endfunction

   function automatic block_type key_bwd(block_type q, byte_type rc);
      block_type p;
      p[95:64]  = q[95:64] ^ q[127:96];
      p[63:32]  = q[63:32] ^ q[95:64];
      p[31:0]   = q[31:0]  ^ q[63:32];
      p[127:96] = q[127:96] ^ key_core(p, rc);
      return p;
   endfunction

endpackage

>>> rtl/core/aescf_if.sv
// Request and response channel interfaces of the cipher core.
// Standalone; carry valid, ready and the transaction payload.
interface aescf_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [63:0] block_upper;
   logic [63:0] block_lower;
   modport source (output valid, command, block_upper, block_lower, input ready);
   modport sink   (input valid, command, block_upper, block_lower, output ready);
endinterface

interface aescf_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result_upper;
   logic [63:0] result_lower;
   modport source (output valid, result_upper, result_lower, input ready);
   modport sink   (input valid, result_upper, result_lower, output ready);
endinterface

>>> rtl/core/aescf_enc_stage.sv
// One forward pipeline stage: next round key, and one encrypt round for encrypt
// transactions. Depends on aescf_pkg.
module aescf_enc_stage #(
   parameter int Round = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  aescf_pkg::stage_type in_data,
   output logic                out_valid,
   output aescf_pkg::stage_type out_data
);
   import aescf_pkg::*;

   logic      valid_ff;
   stage_type data_ff, data_in;
   block_type rk_next, s0, s1;

   // Expand key and run the round
   always_comb begin
      rk_next = key_fwd(in_data.key, RCON[Round - 1]);
      s0      = (Round == 1) ? (in_data.state ^ in_data.key) : in_data.state;
      s1      = shift_fwd(sub_fwd(s0));
      if (Round < NumRounds) begin
         s1 = mix_fwd(s1);
      end
      data_in.cmd   = in_data.cmd;
      data_in.key   = rk_next;
      data_in.state = (in_data.cmd == CmdEncrypt) ? (s1 ^ rk_next) : in_data.state;
   end

   // Advance on enable
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

>>> rtl/core/aescf_dec_stage.sv
// One backward pipeline stage: previous round key, and one decrypt round for
// decrypt transactions. Depends on aescf_pkg.
module aescf_dec_stage #(
   parameter int Round = 9
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  aescf_pkg::stage_type in_data,
   output logic                out_valid,
   output aescf_pkg::stage_type out_data
);
   import aescf_pkg::*;

   logic      valid_ff;
   stage_type data_ff, data_in;
   block_type rk_prev, s0, s1;

   // Step key back and run the inverse round
   always_comb begin
      rk_prev = key_bwd(in_data.key, RCON[Round]);
      s0      = (Round == NumRounds - 1) ? (in_data.state ^ in_data.key) : in_data.state;
      s1      = sub_inv(shift_inv(s0)) ^ rk_prev;
      if (Round > 0) begin
         s1 = mix_inv(s1);
      end
      data_in.cmd   = in_data.cmd;
      data_in.key   = rk_prev;
      data_in.state = (in_data.cmd == CmdDecrypt) ? s1 : in_data.state;
   end

   // Advance on enable
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

>>> rtl/core/aes128_custom_field_cipher_core.sv
// Top level of the custom-field AES-128 cipher: key registers, twenty-stage
// pipeline and flow control. Depends on aescf_pkg, aescf_if and the stage modules.
//
//   Channel | Direction | Contents
//   req_ch  | in        | command, block_upper, block_lower
//   rsp_ch  | out       | result_upper, result_lower
//   csr_*   | in        | key_upper (index 0), key_lower (index 1)
//
// One transaction enters per cycle while req_ch.ready is high; ten stages expand
// the key forward (and encrypt), ten step it back (and decrypt).
// The key is sampled when a transaction enters and travels with it.
// Reset is synchronous and clears every stage valid and both key registers.
// A stalled output holds its stage; bubbles ahead of it still fill.
module aes128_custom_field_cipher_core (
   input  logic        clock,
   input  logic        reset,
   aescf_req_if.sink   req_ch,
   aescf_rsp_if.source rsp_ch,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [63:0] csr_wdata
);
   import aescf_pkg::*;

   localparam int NumStages = 2 * NumRounds;

   logic [63:0] key_upper_ff, key_lower_ff;
   logic        stg_valid [NumStages + 1];
   stage_type   stg_data  [NumStages + 1];
   logic        stg_en    [NumStages];

   // Hold key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_upper_ff <= '0;
         key_lower_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CsrKeyUpper: key_upper_ff <= csr_wdata;
            CsrKeyLower: key_lower_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Feed the pipeline head
   assign stg_valid[0]     = req_ch.valid;
   assign stg_data[0].cmd  = req_ch.command;
   assign stg_data[0].state = {req_ch.block_upper, req_ch.block_lower};
   assign stg_data[0].key  = {key_upper_ff, key_lower_ff};

   // Enable a stage when it is empty or the one after it moves
   always_comb begin
      stg_en[NumStages - 1] = !stg_valid[NumStages] || rsp_ch.ready;
      for (int i = NumStages - 2; i >= 0; i--) begin
         stg_en[i] = !stg_valid[i + 1] || stg_en[i + 1];
      end
   end

   assign req_ch.ready = stg_en[0];

   genvar g;
   generate
      for (g = 0; g < NumRounds; g++) begin : g_enc
         aescf_enc_stage #(.Round(g + 1)) u_enc (
            .clock    (clock),
            .reset    (reset),
            .en       (stg_en[g]),
            .in_valid (stg_valid[g]),
            .in_data  (stg_data[g]),
            .out_valid(stg_valid[g + 1]),
            .out_data (stg_data[g + 1])
         );
      end
      for (g = 0; g < NumRounds; g++) begin : g_dec
         aescf_dec_stage #(.Round(NumRounds - 1 - g)) u_dec (
            .clock    (clock),
            .reset    (reset),
            .en       (stg_en[NumRounds + g]),
            .in_valid (stg_valid[NumRounds + g]),
            .in_data  (stg_data[NumRounds + g]),
            .out_valid(stg_valid[NumRounds + g + 1]),
            .out_data (stg_data[NumRounds + g + 1])
         );
      end
   endgenerate

   // Drive the response from the last stage
   assign rsp_ch.valid        = stg_valid[NumStages];
   assign rsp_ch.result_upper = stg_data[NumStages].state[127:64];
   assign rsp_ch.result_lower = stg_data[NumStages].state[63:0];

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !stg_valid[1] && !stg_valid[NumStages])
      else $error("pipeline not empty after reset");

   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> stg_valid[1])
      else $error("accepted transaction not captured");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid && $stable(stg_data[NumStages]))
      else $error("stalled result lost or changed");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !stg_valid[1] |-> req_ch.ready)
      else $error("empty head stage refused a transaction");
endmodule
